// File: sv/spi_pkg.sv
package spi_pkg;

  localparam int CW     = 32;
  localparam int VW     = CW + 1;
  localparam int NW     = 18;
  localparam int TEW    = 16;
  localparam int FRAC   = 16;
  localparam int PVW    = NW + VW;
  localparam int PSW    = NW + CW;
  localparam int SW     = PVW + 2;
  localparam int UW     = SW - 1;
  localparam int RW     = UW + 2;
  localparam int QB     = FRAC + 2;
  localparam int TW     = QB + 1;
  localparam int PW     = VW + TW;
  localparam int SMW    = PW - FRAC + 2;
  localparam int IDXW   = 3;
  localparam int QDEPTH = 4;

  typedef enum logic [IDXW-1:0] {
    REG_NORMAL_X  = 3'd0,
    REG_NORMAL_Y  = 3'd1,
    REG_NORMAL_Z  = 3'd2,
    REG_OFFSET    = 3'd3,
    REG_T_TOL     = 3'd4,
    REG_PAR_TOL   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic signed [CW-1:0] offset;
    logic [TEW-1:0]       teps;
    logic [TEW-1:0]       ptol;
  } cfg_t;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][VW-1:0] v;
    logic [UW-1:0]      un;
    logic [UW-1:0]      ud;
    logic               neg;
    logic               skip;
  } work_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/spi_in_if.sv
interface spi_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [spi_pkg::CW-1:0] start_x;
  logic signed [spi_pkg::CW-1:0] start_y;
  logic signed [spi_pkg::CW-1:0] start_z;
  logic signed [spi_pkg::CW-1:0] end_x;
  logic signed [spi_pkg::CW-1:0] end_y;
  logic signed [spi_pkg::CW-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

// File: sv/spi_out_if.sv
interface spi_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic signed [spi_pkg::CW-1:0] contact_x;
  logic signed [spi_pkg::CW-1:0] contact_y;
  logic signed [spi_pkg::CW-1:0] contact_z;

  modport source (output valid, hit, contact_x, contact_y, contact_z, input ready);
  modport sink (input valid, hit, contact_x, contact_y, contact_z, output ready);
endinterface

// File: sv/spi_cfg_if.sv
interface spi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spi_pkg::IDXW-1:0]     index;
  logic [spi_pkg::CW-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/spi_front.sv
module spi_front (
  input  logic            clk,
  input  logic            rst_n,
  spi_in_if.sink          in_seg,
  input  spi_pkg::cfg_t   cfg,
  input  logic            full,
  output logic            push,
  output spi_pkg::work_t  entry
);

  logic adv;
  logic f1_valid_r, f2_valid_r, f3_valid_r;

  logic [2:0][spi_pkg::CW-1:0]  s1_r, s2_r, s3_r, s1_nxt;
  logic [2:0][spi_pkg::VW-1:0]  v1_r, v2_r, v3_r, v1_nxt;
  logic [2:0][spi_pkg::PVW-1:0] pv_r, pv_nxt;
  logic [2:0][spi_pkg::PSW-1:0] ps_r, ps_nxt;
  logic signed [spi_pkg::SW-1:0] a_r, a_nxt, num_r, num_nxt;
  logic signed [spi_pkg::NW-1:0] n [3];
  logic [spi_pkg::SW-1:0] ua_w, un_w;

  assign adv          = !full;
  assign in_seg.ready = adv;

  always_comb begin
    n[0] = cfg.nx;
    n[1] = cfg.ny;
    n[2] = cfg.nz;
    s1_nxt[0] = in_seg.start_x;
    s1_nxt[1] = in_seg.start_y;
    s1_nxt[2] = in_seg.start_z;
    v1_nxt[0] = {in_seg.end_x[spi_pkg::CW-1], in_seg.end_x}
              - {in_seg.start_x[spi_pkg::CW-1], in_seg.start_x};
    v1_nxt[1] = {in_seg.end_y[spi_pkg::CW-1], in_seg.end_y}
              - {in_seg.start_y[spi_pkg::CW-1], in_seg.start_y};
    v1_nxt[2] = {in_seg.end_z[spi_pkg::CW-1], in_seg.end_z}
              - {in_seg.start_z[spi_pkg::CW-1], in_seg.start_z};
    for (int k = 0; k < 3; k++) begin
      pv_nxt[k] = n[k] * $signed(v1_r[k]);
      ps_nxt[k] = n[k] * $signed(s1_r[k]);
    end
    a_nxt = $signed(pv_r[0]) + $signed(pv_r[1]) + $signed(pv_r[2]);
    num_nxt = $signed({cfg.offset, {spi_pkg::FRAC{1'b0}}})
            - ($signed(ps_r[0]) + $signed(ps_r[1]) + $signed(ps_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_seg.valid;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      v1_r  <= v1_nxt;
      s2_r  <= s1_r;
      v2_r  <= v1_r;
      pv_r  <= pv_nxt;
      ps_r  <= ps_nxt;
      s3_r  <= s2_r;
      v3_r  <= v2_r;
      a_r   <= a_nxt;
      num_r <= num_nxt;
    end
  end

  // classify: parallel, out-of-range quotient, sign
  always_comb begin
    ua_w = a_r[spi_pkg::SW-1] ? -a_r : a_r;
    un_w = num_r[spi_pkg::SW-1] ? -num_r : num_r;
    entry.s    = s3_r;
    entry.v    = v3_r;
    entry.ud   = ua_w[spi_pkg::UW-1:0];
    entry.un   = un_w[spi_pkg::UW-1:0];
    entry.neg  = a_r[spi_pkg::SW-1] ^ num_r[spi_pkg::SW-1];
    entry.skip = (a_r == '0)
              || (ua_w < {{(spi_pkg::SW-spi_pkg::TEW-spi_pkg::FRAC){1'b0}}, cfg.ptol,
                          {spi_pkg::FRAC{1'b0}}})
              || ({2'b00, un_w} >= {ua_w, 2'b00});
  end

  assign push = f3_valid_r && !full;

endmodule

// File: sv/spi_fifo.sv
module spi_fifo #(
  parameter int DEPTH = spi_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  spi_pkg::work_t din,
  input  logic           pop,
  output spi_pkg::work_t dout,
  output logic           full,
  output logic           empty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  spi_pkg::work_t mem [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/spi_back.sv
module spi_back (
  input  logic           clk,
  input  logic           rst_n,
  input  spi_pkg::cfg_t  cfg,
  input  logic           empty,
  input  spi_pkg::work_t entry,
  output logic           pop,
  spi_out_if.source      out_res
);

  localparam int QB = spi_pkg::QB;
  localparam int RW = spi_pkg::RW;

  logic adv;
  logic out_valid_r, out_hit_r;
  logic [2:0][spi_pkg::CW-1:0] out_c_r, out_c_nxt;

  logic           dv_r [QB];
  spi_pkg::work_t dw_r [QB];
  logic [RW-1:0]  dr_r [QB];
  logic [QB-1:0]  dq_r [QB];

  logic           vin [QB];
  spi_pkg::work_t win [QB];
  logic [RW-1:0]  rin [QB];
  logic [QB-1:0]  qin [QB];

  assign adv = !out_valid_r || out_res.ready;
  assign pop = adv && !empty;

  // one quotient bit per stage: two integer bits, then FRAC fraction bits
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] rs, dd, rn;
    logic          ge;

    if (j == 0) begin : g_first
      assign vin[j] = !empty;
      assign win[j] = entry;
      assign rin[j] = {2'b00, entry.un};
      assign qin[j] = '0;
    end else begin : g_next
      assign vin[j] = dv_r[j-1];
      assign win[j] = dw_r[j-1];
      assign rin[j] = dr_r[j-1];
      assign qin[j] = dq_r[j-1];
    end

    always_comb begin
      rs = (j >= 2) ? {rin[j][RW-2:0], 1'b0} : rin[j];
      dd = (j == 0) ? {1'b0, win[j].ud, 1'b0} : {2'b00, win[j].ud};
      ge = (rs >= dd);
      rn = ge ? rs - dd : rs;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= vin[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dw_r[j] <= win[j];
        dr_r[j] <= rn;
        dq_r[j] <= {qin[j][QB-2:0], ge};
      end
    end
  end

  // range check and signed t
  logic rv_r, rhit_r, rhit_nxt;
  logic signed [spi_pkg::TW-1:0] rt_r, rt_nxt;
  logic [2:0][spi_pkg::CW-1:0] rs_r;
  logic [2:0][spi_pkg::VW-1:0] rvv_r;
  logic [QB-1:0] m_w;
  spi_pkg::work_t lw;

  always_comb begin
    m_w = dq_r[QB-1];
    lw  = dw_r[QB-1];
    if (lw.neg) begin
      rhit_nxt = !lw.skip && (m_w <= {2'b00, cfg.teps});
      rt_nxt   = -$signed({1'b0, m_w});
    end else begin
      rhit_nxt = !lw.skip
              && (m_w <= (QB'(1) << spi_pkg::FRAC) + {2'b00, cfg.teps});
      rt_nxt   = $signed({1'b0, m_w});
    end
  end

  // products
  logic mv_r, mhit_r;
  logic [2:0][spi_pkg::PW-1:0] mp_r, mp_nxt;
  logic [2:0][spi_pkg::CW-1:0] ms_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mp_nxt[k] = $signed(rvv_r[k]) * rt_r;
    end
  end

  // round, add start, saturate; a miss gives zero
  logic signed [spi_pkg::PW:0]    rp;
  logic signed [spi_pkg::SMW-1:0] sm;

  always_comb begin
    rp = '0;
    sm = '0;
    for (int k = 0; k < 3; k++) begin
      rp = $signed(mp_r[k]) + $signed((spi_pkg::PW+1)'(1) << (spi_pkg::FRAC - 1));
      sm = $signed(rp[spi_pkg::PW:spi_pkg::FRAC]) + $signed(ms_r[k]);
      if (!mhit_r) begin
        out_c_nxt[k] = '0;
      end else if (sm[spi_pkg::SMW-1:spi_pkg::CW-1] == '0
                || sm[spi_pkg::SMW-1:spi_pkg::CW-1] == '1) begin
        out_c_nxt[k] = sm[spi_pkg::CW-1:0];
      end else begin
        out_c_nxt[k] = sm[spi_pkg::SMW-1] ? {1'b1, {(spi_pkg::CW-1){1'b0}}}
                                          : {1'b0, {(spi_pkg::CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      rv_r        <= dv_r[QB-1];
      mv_r        <= rv_r;
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rhit_r    <= rhit_nxt;
      rt_r      <= rt_nxt;
      rs_r      <= lw.s;
      rvv_r     <= lw.v;
      mhit_r    <= rhit_r;
      mp_r      <= mp_nxt;
      ms_r      <= rs_r;
      out_hit_r <= mhit_r;
      out_c_r   <= out_c_nxt;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.hit       = out_hit_r;
  assign out_res.contact_x = out_c_r[0];
  assign out_res.contact_y = out_c_r[1];
  assign out_res.contact_z = out_c_r[2];

endmodule

// File: sv/segment_plane_intersection.sv
// Throughput: one item per cycle, unless out_res.ready holds the back end
// and the queue fills; the divider is an 18-stage pipeline, one quotient
// bit per stage, fed from a queue of QDEPTH entries.
// Reset (rst_n low at a clock edge) empties the pipelines and queue and
// loads the plane registers with their defaults.
module segment_plane_intersection #(
  parameter int QDEPTH = spi_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  spi_in_if.sink     in_seg,
  spi_out_if.source  out_res,
  spi_cfg_if.sink    cfg_wr
);

  spi_pkg::cfg_t   cfg_r;
  spi_pkg::work_t  q_in, q_out;
  spi_pkg::q_stat_t q_st;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nx     <= '0;
      cfg_r.ny     <= '0;
      cfg_r.nz     <= spi_pkg::NW'(1) << spi_pkg::FRAC;
      cfg_r.offset <= '0;
      cfg_r.teps   <= '0;
      cfg_r.ptol   <= spi_pkg::TEW'(1);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        spi_pkg::REG_NORMAL_X: cfg_r.nx     <= cfg_wr.data[spi_pkg::NW-1:0];
        spi_pkg::REG_NORMAL_Y: cfg_r.ny     <= cfg_wr.data[spi_pkg::NW-1:0];
        spi_pkg::REG_NORMAL_Z: cfg_r.nz     <= cfg_wr.data[spi_pkg::NW-1:0];
        spi_pkg::REG_OFFSET:   cfg_r.offset <= cfg_wr.data;
        spi_pkg::REG_T_TOL:    cfg_r.teps   <= cfg_wr.data[spi_pkg::TEW-1:0];
        spi_pkg::REG_PAR_TOL:  cfg_r.ptol   <= cfg_wr.data[spi_pkg::TEW-1:0];
        default: ;
      endcase
    end
  end

  spi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg),
    .cfg    (cfg_r),
    .full   (q_st.full),
    .push   (q_st.push),
    .entry  (q_in)
  );

  spi_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_st.push),
    .din   (q_in),
    .pop   (q_st.pop),
    .dout  (q_out),
    .full  (q_st.full),
    .empty (q_st.empty)
  );

  spi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .empty   (q_st.empty),
    .entry   (q_out),
    .pop     (q_st.pop),
    .out_res (out_res)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.hit |->
      out_res.contact_x == '0 && out_res.contact_y == '0 && out_res.contact_z == '0)
    else $error("miss with nonzero contact");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid && in_seg.ready)
    else $error("pipeline not clear after reset");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_st.pop && q_st.empty))
    else $error("queue pop while empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_st.push && q_st.full))
    else $error("queue push while full");

endmodule
